// ----- hdl/skct_pkg.sv -----
// Shared types and codes for the sorted key count table.
package skct_pkg;

   localparam int KEY_IN_BITS = 16;
   localparam int AMOUNT_BITS = 16;
   localparam int INDEX_BITS = 7;
   localparam int OCC_BITS = 8;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [KEY_IN_BITS-1:0] key;
      logic [AMOUNT_BITS-1:0] amount;
      logic [INDEX_BITS-1:0] index;
   } cmd_type;

endpackage

// ----- hdl/skct_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module skct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/skct_front.sv -----
// Request front end: classifies requests and queues them for the table engine.
module skct_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [skct_pkg::KEY_IN_BITS-1:0] req_key,
   input  logic [skct_pkg::AMOUNT_BITS-1:0] req_amount,
   input  logic [skct_pkg::INDEX_BITS-1:0]  req_index,
   output logic                             cmd_valid,
   output skct_pkg::cmd_type                cmd,
   input  logic                             cmd_pop
);

   skct_pkg::cmd_type q_ff [2];
   skct_pkg::cmd_type new_cmd;
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   always_comb begin
      new_cmd.key = req_key;
      new_cmd.amount = req_amount;
      new_cmd.index = req_index;
      unique case (req_action)
         skct_pkg::ACT_INSERT: new_cmd.op = skct_pkg::OP_INSERT;
         skct_pkg::ACT_REMOVE: new_cmd.op = skct_pkg::OP_REMOVE;
         skct_pkg::ACT_READ:   new_cmd.op = skct_pkg::OP_READ;
         default:              new_cmd.op = skct_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign pop = cmd_pop && cmd_valid;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- hdl/skct_back.sv -----
// Table engine: searches, shifts and updates the sorted table held in RAM.
module skct_back #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  skct_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic                             rsp_rejected,
   output logic [skct_pkg::KEY_IN_BITS-1:0] rsp_entry_key,
   output logic [COUNT_BITS-1:0]            rsp_entry_count_raw,
   output logic [skct_pkg::OCC_BITS-1:0]    rsp_occupancy
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int UW = $clog2(TABLE_DEPTH + 1);
   localparam int DW = KEY_BITS + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SRCH = 4'd1;
   localparam logic [3:0] S_CMP = 4'd2;
   localparam logic [3:0] S_RESOLVE = 4'd3;
   localparam logic [3:0] S_SHUP = 4'd4;
   localparam logic [3:0] S_SHUPW = 4'd5;
   localparam logic [3:0] S_SHDN = 4'd6;
   localparam logic [3:0] S_SHDNW = 4'd7;
   localparam logic [3:0] S_RDATA = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   skct_pkg::cmd_type cmd_ff, cmd_in;
   logic [UW-1:0] ptr_ff, ptr_in;
   logic [UW-1:0] pos_ff, pos_in;
   logic [UW-1:0] used_ff, used_in;
   logic match_ff, match_in;
   logic [COUNT_BITS-1:0] cur_cnt_ff, cur_cnt_in;
   logic hit_ff, hit_in;
   logic rej_ff, rej_in;
   logic [skct_pkg::KEY_IN_BITS-1:0] ek_ff, ek_in;
   logic [COUNT_BITS-1:0] ec_ff, ec_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_rej_ff, rsp_rej_in;
   logic [skct_pkg::KEY_IN_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [COUNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [skct_pkg::OCC_BITS-1:0] rsp_occ_ff, rsp_occ_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;

   logic [KEY_BITS-1:0]   rd_key;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [KEY_BITS-1:0]   k;
   logic [31:0]           key_wide;
   logic [31:0]           idx_wide;
   logic [31:0]           rd_key_wide;
   logic [31:0]           used_wide;
   logic [UW:0]           ptr_next;

   assign rd_key = ram_rdata[DW-1:COUNT_BITS];
   assign rd_cnt = ram_rdata[COUNT_BITS-1:0];
   assign key_wide = 32'(cmd_ff.key);
   assign k = key_wide[KEY_BITS-1:0];
   assign idx_wide = 32'(cmd.index);
   assign rd_key_wide = 32'(rd_key);
   assign used_wide = 32'(used_ff);
   assign ptr_next = (UW + 1)'(ptr_ff) + (UW + 1)'(1);

   skct_ram #(
      .WIDTH(DW),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      ptr_in = ptr_ff;
      pos_in = pos_ff;
      used_in = used_ff;
      match_in = match_ff;
      cur_cnt_in = cur_cnt_ff;
      hit_in = hit_ff;
      rej_in = rej_ff;
      ek_in = ek_ff;
      ec_in = ec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in = rsp_hit_ff;
      rsp_rej_in = rsp_rej_ff;
      rsp_key_in = rsp_key_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_occ_in = rsp_occ_ff;
      ram_we = 1'b0;
      ram_waddr = ptr_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = ptr_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               hit_in = 1'b0;
               rej_in = 1'b0;
               ek_in = '0;
               ec_in = '0;
               ptr_in = '0;
               match_in = 1'b0;
               unique case (cmd.op)
                  skct_pkg::OP_INSERT, skct_pkg::OP_REMOVE: begin
                     state_in = S_SRCH;
                  end
                  skct_pkg::OP_READ: begin
                     if (idx_wide < 32'(used_ff)) begin
                        ram_raddr = idx_wide[AW-1:0];
                        state_in = S_RDATA;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SRCH: begin
            if (ptr_ff < used_ff) begin
               state_in = S_CMP;
            end else begin
               pos_in = used_ff;
               match_in = 1'b0;
               state_in = S_RESOLVE;
            end
         end
         S_CMP: begin
            if (k <= rd_key) begin
               pos_in = ptr_ff;
               match_in = (k == rd_key);
               cur_cnt_in = rd_cnt;
               state_in = S_RESOLVE;
            end else begin
               ptr_in = ptr_ff + UW'(1);
               state_in = S_SRCH;
            end
         end
         S_RESOLVE: begin
            ram_waddr = pos_ff[AW-1:0];
            state_in = S_DONE;
            if (cmd_ff.op == skct_pkg::OP_INSERT) begin
               if (match_ff) begin
                  hit_in = 1'b1;
                  ram_we = 1'b1;
                  ram_wdata = {k, (cur_cnt_ff == COUNT_MAX) ? cur_cnt_ff
                                                            : cur_cnt_ff + COUNT_BITS'(1)};
               end else if (32'(used_ff) >= 32'(TABLE_DEPTH)) begin
                  rej_in = 1'b1;
               end else begin
                  ptr_in = used_ff;
                  state_in = S_SHUP;
               end
            end else if (match_ff) begin
               hit_in = 1'b1;
               if (32'(cmd_ff.amount) < 32'(cur_cnt_ff)) begin
                  ram_we = 1'b1;
                  ram_wdata = {k, cur_cnt_ff - COUNT_BITS'(cmd_ff.amount)};
               end else begin
                  ptr_in = pos_ff;
                  state_in = S_SHDN;
               end
            end
         end
         S_SHUP: begin
            if (ptr_ff > pos_ff) begin
               ram_raddr = AW'(ptr_ff - UW'(1));
               state_in = S_SHUPW;
            end else begin
               ram_we = 1'b1;
               ram_waddr = pos_ff[AW-1:0];
               ram_wdata = {k, COUNT_BITS'(1)};
               used_in = used_ff + UW'(1);
               state_in = S_DONE;
            end
         end
         S_SHUPW: begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in = ptr_ff - UW'(1);
            state_in = S_SHUP;
         end
         S_SHDN: begin
            if (ptr_next < (UW + 1)'(used_ff)) begin
               ram_raddr = ptr_next[AW-1:0];
               state_in = S_SHDNW;
            end else begin
               used_in = used_ff - UW'(1);
               state_in = S_DONE;
            end
         end
         S_SHDNW: begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in = ptr_next[UW-1:0];
            state_in = S_SHDN;
         end
         S_RDATA: begin
            hit_in = 1'b1;
            ek_in = rd_key_wide[skct_pkg::KEY_IN_BITS-1:0];
            ec_in = rd_cnt;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit_ff;
               rsp_rej_in = rej_ff;
               rsp_key_in = ek_ff;
               rsp_cnt_in = ec_ff;
               rsp_occ_in = used_wide[skct_pkg::OCC_BITS-1:0];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      match_ff <= match_in;
      cur_cnt_ff <= cur_cnt_in;
      hit_ff <= hit_in;
      rej_ff <= rej_in;
      ek_ff <= ek_in;
      ec_ff <= ec_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_rej_ff <= rsp_rej_in;
      rsp_key_ff <= rsp_key_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_rejected = rsp_rej_ff;
   assign rsp_entry_key = rsp_key_ff;
   assign rsp_entry_count_raw = rsp_cnt_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(TABLE_DEPTH))
      else $error("occupancy exceeds table depth");

   a_rej_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rej_ff |-> !rsp_hit_ff)
      else $error("rejected request also reports a hit");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && cmd_valid |=> state_ff != S_IDLE)
      else $error("popped request did not start");

endmodule

// ----- hdl/sorted_key_count_table.sv -----
// Top level of the sorted key count table.
// Requests are queued two deep; the engine serves one request at a time.
// A read fetches the entry at its index from the table RAM and then gives its response.
// Insert and remove scan the entries in key order, then shift entries up or down as needed,
// using the single table RAM port pair.
// Synchronous reset empties the table and queue; stored entries are not cleared.
module sorted_key_count_table #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [skct_pkg::KEY_IN_BITS-1:0] req_key,
   input  logic [skct_pkg::AMOUNT_BITS-1:0] req_amount,
   input  logic [skct_pkg::INDEX_BITS-1:0]  req_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic                             rsp_rejected,
   output logic [15:0]                      rsp_entry_key,
   output logic [15:0]                      rsp_entry_count,
   output logic [skct_pkg::OCC_BITS-1:0]    rsp_occupancy
);

   logic                  cmd_valid;
   skct_pkg::cmd_type     cmd;
   logic                  cmd_pop;
   logic [COUNT_BITS-1:0] count_raw;
   logic [31:0]           count_wide;

   skct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_action),
      .req_key   (req_key),
      .req_amount(req_amount),
      .req_index (req_index),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   skct_back #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_rejected       (rsp_rejected),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_count_raw(count_raw),
      .rsp_occupancy      (rsp_occupancy)
   );

   assign count_wide = 32'(count_raw);
   assign rsp_entry_count = count_wide[15:0];

endmodule

// ----- tb/sorted_key_count_table_tb.sv -----
// Testbench for the sorted key count table: directed and random requests checked against a table model.
`timescale 1ns / 100ps
module sorted_key_count_table_tb;

   localparam int DEPTH = 128;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [1:0] action;
      logic [15:0] key;
      logic [15:0] amount;
      logic [6:0] index;
      bit drain;
   } request_type;

   typedef struct {
      logic hit;
      logic rejected;
      logic [15:0] entry_key;
      logic [15:0] entry_count;
      logic [7:0] occupancy;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = '0;
   logic [15:0] req_key = '0;
   logic [15:0] req_amount = '0;
   logic [6:0] req_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic rsp_rejected;
   logic [15:0] rsp_entry_key;
   logic [15:0] rsp_entry_count;
   logic [7:0] rsp_occupancy;

   request_type pending_requests[$];
   outcome_type expected_outcomes[$];
   logic [15:0] model_keys[DEPTH];
   logic [15:0] model_counts[DEPTH];
   int model_used = 0;
   int errors = 0;
   int idle_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   sorted_key_count_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_key(req_key), .req_amount(req_amount), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_rejected(rsp_rejected), .rsp_entry_key(rsp_entry_key),
      .rsp_entry_count(rsp_entry_count), .rsp_occupancy(rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int lower_bound(logic [15:0] k);
      for (int i = 0; i < model_used; i++) begin
         if (k <= model_keys[i]) return i;
      end
      return model_used;
   endfunction

   function automatic outcome_type apply_request(request_type r);
      outcome_type o;
      int pos;
      o = '{1'b0, 1'b0, 16'd0, 16'd0, 8'd0};
      pos = lower_bound(r.key);
      case (r.action)
         skct_pkg::ACT_INSERT: begin
            if (pos < model_used && model_keys[pos] == r.key) begin
               if (model_counts[pos] != COUNT_TOP) model_counts[pos]++;
               o.hit = 1'b1;
            end else if (model_used >= DEPTH) begin
               o.rejected = 1'b1;
            end else begin
               for (int j = model_used; j > pos; j--) begin
                  model_keys[j] = model_keys[j-1];
                  model_counts[j] = model_counts[j-1];
               end
               model_keys[pos] = r.key;
               model_counts[pos] = 16'd1;
               model_used++;
            end
         end
         skct_pkg::ACT_REMOVE: begin
            if (pos < model_used && model_keys[pos] == r.key) begin
               o.hit = 1'b1;
               if (r.amount < model_counts[pos]) begin
                  model_counts[pos] -= r.amount;
               end else begin
                  for (int j = pos; j + 1 < model_used; j++) begin
                     model_keys[j] = model_keys[j+1];
                     model_counts[j] = model_counts[j+1];
                  end
                  model_used--;
               end
            end
         end
         skct_pkg::ACT_READ: begin
            if (r.index < model_used) begin
               o.hit = 1'b1;
               o.entry_key = model_keys[r.index];
               o.entry_count = model_counts[r.index];
            end
         end
         default: ;
      endcase
      o.occupancy = model_used[7:0];
      return o;
   endfunction

   task automatic add_request(logic [1:0] a, logic [15:0] k, logic [15:0] amt,
                              logic [6:0] idx, bit drain = 0);
      request_type r;
      r = '{a, k, amt, idx, drain};
      pending_requests.push_back(r);
   endtask

   always @(posedge clock) begin : driver
      bit free;
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         free = !req_valid || req_ready;
         if (req_valid && req_ready) begin
            r = pending_requests.pop_front();
            expected_outcomes.push_back(apply_request(r));
         end
         if (free) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 200 && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && expected_outcomes.size() > 0)) begin
               req_valid <= 1'b1;
               req_action <= pending_requests[0].action;
               req_key <= pending_requests[0].key;
               req_amount <= pending_requests[0].amount;
               req_index <= pending_requests[0].index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      outcome_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected response, actual hit=%0b rej=%0b key=%h cnt=%h occ=%0d",
                        $time, rsp_hit, rsp_rejected, rsp_entry_key, rsp_entry_count,
                        rsp_occupancy);
               errors++;
            end else begin
               e = expected_outcomes.pop_front();
               if (rsp_hit !== e.hit || rsp_rejected !== e.rejected ||
                   rsp_entry_key !== e.entry_key || rsp_entry_count !== e.entry_count ||
                   rsp_occupancy !== e.occupancy) begin
                  $display("%0t: mismatch, expected hit=%0b rej=%0b key=%h cnt=%h occ=%0d",
                           $time, e.hit, e.rejected, e.entry_key, e.entry_count, e.occupancy);
                  $display("%0t:           actual hit=%0b rej=%0b key=%h cnt=%h occ=%0d",
                           $time, rsp_hit, rsp_rejected, rsp_entry_key, rsp_entry_count,
                           rsp_occupancy);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (pending_requests.size() > 200 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [15:0] pool[$];
      logic [15:0] k;
      int mode;
      int roll;

      // Empty-table corner cases, key extremes and the unused action.
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_REMOVE, 16'h1234, 16'd1, 7'd0);
      add_request(skct_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 7'h7F);
      add_request(skct_pkg::ACT_INSERT, 16'h0000, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_INSERT, 16'hFFFF, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_INSERT, 16'hFFFF, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_INSERT, 16'h8000, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_REMOVE, 16'hFFFF, 16'd0, 7'd0);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'd1);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'd2);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'h7F);
      add_request(skct_pkg::ACT_REMOVE, 16'hFFFF, 16'hFFFF, 7'd0);
      add_request(skct_pkg::ACT_REMOVE, 16'h8000, 16'd1, 7'd0);
      add_request(skct_pkg::OP_NONE, 16'h0000, 16'd0, 7'd0);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_REMOVE, 16'h0000, 16'hFFFE, 7'd0);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'd0);
      add_request(skct_pkg::ACT_REMOVE, 16'h0000, 16'd1, 7'd0);
      // Fill the table, then probe it while full.
      for (int i = 0; i < DEPTH; i++) begin
         k = 16'((i * 40503 + 17) & 16'hFFFF);
         pool.push_back(k);
         add_request(skct_pkg::ACT_INSERT, k, 16'd1, 7'd0);
      end
      add_request(skct_pkg::ACT_INSERT, 16'h0001, 16'd1, 7'd0, 1);
      add_request(skct_pkg::ACT_INSERT, pool[5], 16'd1, 7'd0);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'h7F);
      add_request(skct_pkg::ACT_READ, 16'h0000, 16'd1, 7'd0);
      foreach (pool[i]) add_request(skct_pkg::ACT_REMOVE, pool[i], 16'hFFFF, 7'd0);

      // Random phases: fill-heavy, drain-heavy and mixed, with a small key pool for hits.
      pool.delete();
      for (int i = 0; i < 160; i++) pool.push_back(16'($urandom));
      for (int i = 0; i < 1020; i++) begin
         if (i % 200 == 0) mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, 159)];
         if (roll < 3) begin
            add_request(skct_pkg::OP_NONE, 16'($urandom), 16'($urandom), 7'($urandom));
         end else if (roll < 25) begin
            add_request(skct_pkg::ACT_READ, 16'($urandom), 16'($urandom), 7'($urandom),
                        $urandom_range(0, 60) == 0);
         end else if ((mode == 0 && roll < 85) || (mode == 1 && roll < 45) ||
                      (mode == 2 && roll < 62)) begin
            add_request(skct_pkg::ACT_INSERT, k, 16'($urandom), 7'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: add_request(skct_pkg::ACT_REMOVE, k, 16'd0, 7'($urandom));
               1: add_request(skct_pkg::ACT_REMOVE, k, 16'hFFFF, 7'($urandom));
               default: add_request(skct_pkg::ACT_REMOVE, k, 16'($urandom_range(1, 3)),
                                    7'($urandom));
            endcase
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_requests.size() == 0);
      wait (expected_outcomes.size() == 0);
      repeat (1200) @(posedge clock);
      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hdl/skct_pkg.sv
hdl/skct_ram.sv
hdl/skct_front.sv
hdl/skct_back.sv
hdl/sorted_key_count_table.sv
tb/sorted_key_count_table_tb.sv
